[hdl/lsf_pkg.sv]
// ----------------------------------------------------------------------------
// lsf_pkg - shared types and codes of the linear spring force unit
// request layout between the front queue and the back sequencer, mode and
// status codes
// ----------------------------------------------------------------------------
package lsf_pkg;

	localparam logic [1:0] MODE_2D   = 2'd0;
	localparam logic [1:0] MODE_3D   = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_ZERO_LEN  = 2'd1;
	localparam logic [1:0] STAT_ZERO_REST = 2'd2;
	localparam logic [1:0] STAT_SAT       = 2'd3;

	typedef enum logic [1:0] {
		OP_SPRING,
		OP_READ,
		OP_NOP
	} op_t;

	// classified request: magnitudes and signs of the position differences
	typedef struct packed {
		op_t              op;
		logic [7:0]       idx1;
		logic [7:0]       idx2;
		logic             v1;
		logic             v2;
		logic [2:0]       neg;
		logic [2:0][32:0] mag;
		logic [30:0]      stiff;
		logic [30:0]      rest;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	typedef struct packed {
		logic deq;
		logic clearing;
	} back_ctl_t;

endpackage

[hdl/lsf_ram.sv]
// ----------------------------------------------------------------------------
// lsf_ram - generic single write, single read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module lsf_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/lsf_mul.sv]
// ----------------------------------------------------------------------------
// lsf_mul - sequential 33 x 33 unsigned multiplier
// two partial products, 33 x 16 and 33 x 17, registered and summed in turn
// ----------------------------------------------------------------------------
module lsf_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] a,
	input  logic [32:0] b,
	output logic        done,
	output logic [65:0] p
);
	import lsf_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LO,
		PH_HI,
		PH_SUM
	} phase_t;

	phase_t      ph_q;
	logic [32:0] a_q;
	logic [32:0] b_q;
	logic [49:0] pp_q;
	logic [65:0] acc_q;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				PH_IDLE: begin
					if (start) begin
						a_q  <= a;
						b_q  <= b;
						ph_q <= PH_LO;
					end
				end
				PH_LO: begin
					pp_q <= 50'(a_q) * 50'(b_q[15:0]);
					ph_q <= PH_HI;
				end
				PH_HI: begin
					acc_q <= 66'(pp_q);
					pp_q  <= 50'(a_q) * 50'(b_q[32:16]);
					ph_q  <= PH_SUM;
				end
				PH_SUM: begin
					acc_q  <= acc_q + (66'(pp_q) << 16);
					done_q <= 1'b1;
					ph_q   <= PH_IDLE;
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

[hdl/lsf_div.sv]
// ----------------------------------------------------------------------------
// lsf_div - iterative unsigned divider, 64 by 33 bits
// restoring division, two quotient bits a cycle
// ----------------------------------------------------------------------------
module lsf_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [32:0] den,
	output logic        done,
	output logic [63:0] quo
);
	import lsf_pkg::*;

	logic [63:0] n_q;
	logic [33:0] r_q;
	logic [32:0] d_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] n_nx;
	logic [33:0] r_nx;
	logic [33:0] r_sh;

	always_comb begin
		n_nx = n_q;
		r_nx = r_q;
		r_sh = '0;
		for (int i = 0; i < 2; i++) begin
			r_sh = {r_nx[32:0], n_nx[63]};
			n_nx = {n_nx[62:0], 1'b0};
			if (r_sh >= {1'b0, d_q}) begin
				r_nx    = r_sh - {1'b0, d_q};
				n_nx[0] = 1'b1;
			end else begin
				r_nx = r_sh;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				n_q    <= num;
				d_q    <= den;
				r_q    <= '0;
				cnt_q  <= 5'd31;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				n_q   <= n_nx;
				r_q   <= r_nx;
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = n_q;

endmodule

[hdl/lsf_sqrt.sv]
// ----------------------------------------------------------------------------
// lsf_sqrt - iterative integer square root of a 66-bit value
// digit by digit method, two root bits a cycle
// ----------------------------------------------------------------------------
module lsf_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [65:0] rad,
	output logic        done,
	output logic [32:0] root
);
	import lsf_pkg::*;

	logic [67:0] x_q;
	logic [33:0] root_q;
	logic [36:0] rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [67:0] x_nx;
	logic [33:0] root_nx;
	logic [36:0] rem_nx;
	logic [36:0] rsh;
	logic [36:0] trial;

	always_comb begin
		x_nx    = x_q;
		root_nx = root_q;
		rem_nx  = rem_q;
		rsh     = '0;
		trial   = '0;
		for (int i = 0; i < 2; i++) begin
			rsh   = {rem_nx[34:0], x_nx[67:66]};
			x_nx  = {x_nx[65:0], 2'b00};
			trial = {1'b0, root_nx, 2'b01};
			if (rsh >= trial) begin
				rem_nx  = rsh - trial;
				root_nx = {root_nx[32:0], 1'b1};
			end else begin
				rem_nx  = rsh;
				root_nx = {root_nx[32:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				x_q    <= {2'b00, rad};
				root_q <= '0;
				rem_q  <= '0;
				cnt_q  <= 5'd16;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				x_q    <= x_nx;
				root_q <= root_nx;
				rem_q  <= rem_nx;
				cnt_q  <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q[32:0];

endmodule

[hdl/lsf_front.sv]
// ----------------------------------------------------------------------------
// lsf_front - request intake and classification
// input register, position differences and index checks, two-entry queue
// ----------------------------------------------------------------------------
module lsf_front #(
	parameter int NUM_PARTICLES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         mode,
	input  logic [7:0]         first_index,
	input  logic [7:0]         second_index,
	input  logic signed [31:0] first_x,
	input  logic signed [31:0] first_y,
	input  logic signed [31:0] first_z,
	input  logic signed [31:0] second_x,
	input  logic signed [31:0] second_y,
	input  logic signed [31:0] second_z,
	input  logic [30:0]        spring_stiffness,
	input  logic [30:0]        rest_length,
	input  lsf_pkg::back_ctl_t ctl,
	output lsf_pkg::head_t     head
);
	import lsf_pkg::*;

	localparam int IDX_EXT_W = 17;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);

	logic             valid_s1;
	logic [1:0]       mode_s1;
	logic [7:0]       idx1_s1;
	logic [7:0]       idx2_s1;
	logic [2:0][31:0] a_s1;
	logic [2:0][31:0] b_s1;
	logic [30:0]      stiff_s1;
	logic [30:0]      rest_s1;

	item_t            cls;
	logic [2:0][32:0] d;
	item_t            q_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic             accept;
	logic             move;

	assign move   = valid_s1 && (cnt_q != (QPTR_W+1)'(QDEPTH));
	assign full   = ctl.clearing || (valid_s1 && !move);
	assign accept = push && !full;

	always_comb begin
		cls       = '0;
		cls.idx1  = idx1_s1;
		cls.idx2  = idx2_s1;
		cls.stiff = stiff_s1;
		cls.rest  = rest_s1;
		cls.v1    = IDX_EXT_W'(idx1_s1) < IDX_EXT_W'(NUM_PARTICLES);
		cls.v2    = IDX_EXT_W'(idx2_s1) < IDX_EXT_W'(NUM_PARTICLES);
		case (mode_s1)
			MODE_2D, MODE_3D: cls.op = OP_SPRING;
			MODE_READ:        cls.op = OP_READ;
			default:          cls.op = OP_NOP;
		endcase
		for (int k = 0; k < 3; k++) begin
			d[k] = {b_s1[k][31], b_s1[k]} - {a_s1[k][31], a_s1[k]};
			// z does not take part in a planar spring
			if (k == 2 && mode_s1 != MODE_3D) begin
				d[k] = '0;
			end
			cls.neg[k] = d[k][32];
			cls.mag[k] = d[k][32] ? (33'd0 - d[k]) : d[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			wr_q     <= '0;
			rd_q     <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				wr_q <= wr_q + 1'b1;
			end
			if (ctl.deq) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(move) - (QPTR_W+1)'(ctl.deq);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= mode;
			idx1_s1  <= first_index;
			idx2_s1  <= second_index;
			a_s1     <= {first_z, first_y, first_x};
			b_s1     <= {second_z, second_y, second_x};
			stiff_s1 <= spring_stiffness;
			rest_s1  <= rest_length;
		end
		if (move) begin
			q_q[wr_q] <= cls;
		end
	end

	assign head.valid = cnt_q != '0;
	assign head.item  = q_q[rd_q];

endmodule

[hdl/lsf_back.sv]
// ----------------------------------------------------------------------------
// lsf_back - spring evaluation and accumulator read-and-clear sequencer
// length, strain, stress and force through shared multiply, divide and root
// units, accumulator read-modify-write, result register
// ----------------------------------------------------------------------------
module lsf_back #(
	parameter int NUM_PARTICLES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lsf_pkg::head_t     head,
	output lsf_pkg::back_ctl_t ctl,
	input  logic               pop,
	output logic               empty,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] force_z,
	output logic signed [31:0] strain_value,
	output logic signed [31:0] stress_value,
	output logic [1:0]         status
);
	import lsf_pkg::*;

	localparam int AW = $clog2(NUM_PARTICLES);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_SQ,
		ST_SQRT,
		ST_STRAIN,
		ST_STRESS,
		ST_FMUL,
		ST_FDIV,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_FINISH
	} state_t;

	state_t           state_q;
	item_t            it_q;
	logic [1:0]       k_q;
	logic             side_q;
	logic [AW-1:0]    clr_q;
	logic [65:0]      sum_q;
	logic [32:0]      len_q;
	logic [32:0]      smag_q;
	logic             diff_neg_q;
	logic [31:0]      strain_q;
	logic [31:0]      stress_q;
	logic [2:0][31:0] f_q;
	logic             sat_q;
	logic [1:0]       status_q;
	logic             out_valid_q;
	logic [31:0]      fx_q, fy_q, fz_q, strain_out_q, stress_out_q;
	logic [1:0]       status_out_q;

	logic             mul_start_q;
	logic [32:0]      mul_a_q;
	logic [32:0]      mul_b_q;
	logic             mul_done;
	logic [65:0]      mul_p;
	logic             div_start_q;
	logic [63:0]      div_num_q;
	logic [32:0]      div_den_q;
	logic             div_done;
	logic [63:0]      div_quo;
	logic             sqrt_start_q;
	logic             sqrt_done;
	logic [32:0]      sqrt_root;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [AW-1:0]    ram_raddr;
	logic [95:0]      ram_wdata;
	logic [2:0][31:0] ram_rdata;

	logic [16:0]      i1_ext;
	logic [16:0]      i2_ext;
	logic [AW-1:0]    side_addr;
	logic [33:0]      diff;
	logic [33:0]      diff_mag;
	logic [32:0]      strain_res;
	logic [32:0]      stress_res;
	logic [32:0]      force_res;
	logic [2:0][31:0] acc_new;
	logic             acc_sat;
	logic [33:0]      acc_sum;

	// saturate a sign and magnitude to signed 32 bits, flag in the top bit
	function automatic logic [32:0] sat_s32(input logic neg, input logic [63:0] m);
		logic [32:0] r;
		if (!neg) begin
			r = (m > 64'h7FFF_FFFF) ? {1'b1, 32'h7FFF_FFFF} : {1'b0, m[31:0]};
		end else begin
			r = (m > 64'h8000_0000) ? {1'b1, 32'h8000_0000} : {1'b0, 32'd0 - m[31:0]};
		end
		return r;
	endfunction

	function automatic logic [32:0] abs33(input logic [31:0] v);
		return v[31] ? (33'd0 - {1'b1, v}) : {1'b0, v};
	endfunction

	lsf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	lsf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	lsf_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start_q),
		.rad    (sum_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	lsf_ram #(
		.W     (96),
		.DEPTH (NUM_PARTICLES)
	) u_acc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign i1_ext    = 17'(it_q.idx1);
	assign i2_ext    = 17'(it_q.idx2);
	assign side_addr = side_q ? i2_ext[AW-1:0] : i1_ext[AW-1:0];

	assign diff       = {1'b0, sqrt_root} - {3'b000, it_q.rest};
	assign diff_mag   = diff[33] ? (34'd0 - diff) : diff;
	assign strain_res = sat_s32(diff_neg_q, div_quo);
	assign stress_res = sat_s32(strain_q[31], {16'd0, mul_p[63:16]});
	assign force_res  = sat_s32(it_q.neg[k_q] ^ stress_q[31], div_quo);

	// second particle takes the force with opposite sign
	always_comb begin
		acc_sat = 1'b0;
		acc_sum = '0;
		for (int c = 0; c < 3; c++) begin
			if (side_q) begin
				acc_sum = {{2{ram_rdata[c][31]}}, ram_rdata[c]} - {{2{f_q[c][31]}}, f_q[c]};
			end else begin
				acc_sum = {{2{ram_rdata[c][31]}}, ram_rdata[c]} + {{2{f_q[c][31]}}, f_q[c]};
			end
			if (acc_sum[33:31] != 3'b000 && acc_sum[33:31] != 3'b111) begin
				acc_sat    = 1'b1;
				acc_new[c] = acc_sum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else begin
				acc_new[c] = acc_sum[31:0];
			end
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = i1_ext[AW-1:0];
		ram_wdata = '0;
		ram_raddr = i1_ext[AW-1:0];
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_RD_DATA: ram_we = 1'b1;
			ST_ACC_RD:  ram_raddr = side_addr;
			ST_ACC_WR: begin
				ram_we    = 1'b1;
				ram_waddr = side_addr;
				ram_wdata = acc_new;
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			k_q          <= '0;
			side_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			mul_start_q  <= 1'b0;
			div_start_q  <= 1'b0;
			sqrt_start_q <= 1'b0;
		end else begin
			mul_start_q  <= 1'b0;
			div_start_q  <= 1'b0;
			sqrt_start_q <= 1'b0;
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NUM_PARTICLES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head.valid) begin
						it_q     <= head.item;
						sat_q    <= 1'b0;
						status_q <= STAT_OK;
						f_q      <= '0;
						strain_q <= '0;
						stress_q <= '0;
						sum_q    <= '0;
						k_q      <= '0;
						case (head.item.op)
							OP_SPRING: begin
								mul_a_q     <= head.item.mag[0];
								mul_b_q     <= head.item.mag[0];
								mul_start_q <= 1'b1;
								state_q     <= ST_SQ;
							end
							OP_READ: state_q <= head.item.v1 ? ST_RD_ADDR : ST_FINISH;
							default: state_q <= ST_FINISH;
						endcase
					end
				end
				ST_RD_ADDR: state_q <= ST_RD_DATA;
				ST_RD_DATA: begin
					f_q     <= ram_rdata;
					state_q <= ST_FINISH;
				end
				ST_SQ: begin
					if (mul_done) begin
						sum_q <= sum_q + mul_p;
						if (k_q == 2'd2) begin
							sqrt_start_q <= 1'b1;
							state_q      <= ST_SQRT;
						end else begin
							k_q         <= k_q + 2'd1;
							mul_a_q     <= it_q.mag[k_q + 2'd1];
							mul_b_q     <= it_q.mag[k_q + 2'd1];
							mul_start_q <= 1'b1;
						end
					end
				end
				ST_SQRT: begin
					if (sqrt_done) begin
						len_q <= sqrt_root;
						if (it_q.rest == '0) begin
							status_q <= STAT_ZERO_REST;
							state_q  <= ST_FINISH;
						end else begin
							diff_neg_q  <= diff[33];
							div_num_q   <= {14'd0, diff_mag, 16'd0};
							div_den_q   <= {2'b00, it_q.rest};
							div_start_q <= 1'b1;
							state_q     <= ST_STRAIN;
						end
					end
				end
				ST_STRAIN: begin
					if (div_done) begin
						strain_q    <= strain_res[31:0];
						sat_q       <= sat_q | strain_res[32];
						mul_a_q     <= abs33(strain_res[31:0]);
						mul_b_q     <= {2'b00, it_q.stiff};
						mul_start_q <= 1'b1;
						state_q     <= ST_STRESS;
					end
				end
				ST_STRESS: begin
					if (mul_done) begin
						stress_q <= stress_res[31:0];
						sat_q    <= sat_q | stress_res[32];
						smag_q   <= abs33(stress_res[31:0]);
						if (len_q == '0) begin
							status_q <= STAT_ZERO_LEN;
							state_q  <= ST_FINISH;
						end else begin
							k_q         <= '0;
							mul_a_q     <= it_q.mag[0];
							mul_b_q     <= abs33(stress_res[31:0]);
							mul_start_q <= 1'b1;
							state_q     <= ST_FMUL;
						end
					end
				end
				ST_FMUL: begin
					if (mul_done) begin
						div_num_q   <= mul_p[63:0];
						div_den_q   <= len_q;
						div_start_q <= 1'b1;
						state_q     <= ST_FDIV;
					end
				end
				ST_FDIV: begin
					if (div_done) begin
						f_q[k_q] <= force_res[31:0];
						sat_q    <= sat_q | force_res[32];
						if (k_q == 2'd2) begin
							if (it_q.v1) begin
								side_q  <= 1'b0;
								state_q <= ST_ACC_RD;
							end else if (it_q.v2) begin
								side_q  <= 1'b1;
								state_q <= ST_ACC_RD;
							end else begin
								state_q <= ST_FINISH;
							end
						end else begin
							k_q         <= k_q + 2'd1;
							mul_a_q     <= it_q.mag[k_q + 2'd1];
							mul_b_q     <= smag_q;
							mul_start_q <= 1'b1;
							state_q     <= ST_FMUL;
						end
					end
				end
				ST_ACC_RD: state_q <= ST_ACC_WR;
				ST_ACC_WR: begin
					sat_q <= sat_q | acc_sat;
					if (!side_q && it_q.v2) begin
						side_q  <= 1'b1;
						state_q <= ST_ACC_RD;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || pop) begin
						fx_q         <= f_q[0];
						fy_q         <= f_q[1];
						fz_q         <= f_q[2];
						strain_out_q <= strain_q;
						stress_out_q <= stress_q;
						status_out_q <= sat_q ? STAT_SAT : status_q;
						out_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	assign ctl.deq      = (state_q == ST_IDLE) && head.valid;
	assign ctl.clearing = state_q == ST_CLEAR;

	assign empty        = !out_valid_q;
	assign force_x      = fx_q;
	assign force_y      = fy_q;
	assign force_z      = fz_q;
	assign strain_value = strain_out_q;
	assign stress_value = stress_out_q;
	assign status       = status_out_q;

endmodule

[hdl/linear_spring_force_unit.sv]
// one request is evaluated at a time; a spring holds the back through four
// divisions on the shared divider, the square root and the multiplies
// reset: asynchronous, active low; afterwards a clearing pass zeroes the
// accumulators while full stays high
// ----------------------------------------------------------------------------
// linear_spring_force_unit - hookean spring force with per-particle sums
// computes length, strain, stress and force of one spring per request and
// keeps saturating force accumulators for every particle
// ----------------------------------------------------------------------------
module linear_spring_force_unit #(
	parameter int NUM_PARTICLES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         mode,
	input  logic [7:0]         first_index,
	input  logic [7:0]         second_index,
	input  logic signed [31:0] first_x,
	input  logic signed [31:0] first_y,
	input  logic signed [31:0] first_z,
	input  logic signed [31:0] second_x,
	input  logic signed [31:0] second_y,
	input  logic signed [31:0] second_z,
	input  logic [30:0]        spring_stiffness,
	input  logic [30:0]        rest_length,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] force_z,
	output logic signed [31:0] strain_value,
	output logic signed [31:0] stress_value,
	output logic [1:0]         status
);
	import lsf_pkg::*;

	// classified request at the head of the queue, and the back's handshake
	head_t     head;
	back_ctl_t ctl;

	// front: registers the request, forms position differences and their
	// magnitudes, checks indices, and holds up to two classified requests
	lsf_front #(
		.NUM_PARTICLES (NUM_PARTICLES)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.mode             (mode),
		.first_index      (first_index),
		.second_index     (second_index),
		.first_x          (first_x),
		.first_y          (first_y),
		.first_z          (first_z),
		.second_x         (second_x),
		.second_y         (second_y),
		.second_z         (second_z),
		.spring_stiffness (spring_stiffness),
		.rest_length      (rest_length),
		.ctl              (ctl),
		.head             (head)
	);

	// back: sequences the arithmetic, updates the accumulator ram and keeps
	// the result register, so a finished result can wait while the next
	// request is worked on
	lsf_back #(
		.NUM_PARTICLES (NUM_PARTICLES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.ctl          (ctl),
		.pop          (pop),
		.empty        (empty),
		.force_x      (force_x),
		.force_y      (force_y),
		.force_z      (force_z),
		.strain_value (strain_value),
		.stress_value (stress_value),
		.status       (status)
	);

`ifndef SYNTH
	// no request may enter while the accumulators are being cleared
	a_hold_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clearing |-> full)
		else $error("request intake open during clearing pass");

	// a zero rest length result carries no force and no strain
	a_zero_rest_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == STAT_ZERO_REST) |->
		(force_x == 0 && force_y == 0 && force_z == 0 && strain_value == 0))
		else $error("zero rest length result not zero");

	// coincident points give no force
	a_zero_len_no_force: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == STAT_ZERO_LEN) |->
		(force_x == 0 && force_y == 0 && force_z == 0))
		else $error("zero length result carries force");
`endif

endmodule

[bench/tb_linear_spring_force_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_spring_force_unit - self-checking bench of the spring force unit
// drives spring, read and no-op requests through the push/full side, pops
// results with a stall pattern of its own and compares each one with a
// predictor that keeps its own copy of the per-particle force sums
// ----------------------------------------------------------------------------
module tb_linear_spring_force_unit;
	import lsf_pkg::*;

	localparam int  PARTICLES   = 256;
	localparam int  CYCLE_LIMIT = 2_000_000;
	localparam int  RANDOM_REQS = 1150;
	localparam logic [1:0] MODE_NOP = 2'd3;

	// one request as seen on the input ports
	typedef struct {
		logic [1:0]         mode;
		logic [7:0]         idx1;
		logic [7:0]         idx2;
		logic signed [31:0] p1 [3];
		logic signed [31:0] p2 [3];
		logic [30:0]        stiff;
		logic [30:0]        rest;
	} spring_req_t;

	// one result as seen on the output ports
	typedef struct {
		logic signed [31:0] f [3];
		logic signed [31:0] strain;
		logic signed [31:0] stress;
		logic [1:0]         stat;
	} spring_res_t;

	// scoreboard: force predictor plus the queue of results still owed
	class force_scoreboard;
		longint      sum_f [3][PARTICLES];
		spring_res_t owed [$];
		bit          clipped;
		int          errors;

		function new();
			foreach (sum_f[k, i]) sum_f[k][i] = 0;
			errors = 0;
		endfunction

		function longint clip32(longint v);
			if (v > 64'sd2147483647) begin
				clipped = 1;
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				clipped = 1;
				return -64'sd2147483648;
			end
			return v;
		endfunction

		// request accepted: work out the result it causes, update the sums
		function void note(spring_req_t r);
			spring_res_t  e;
			longint       d [3];
			longint       fv [3];
			logic [127:0] sq, cand, len, p, md;
			longint       diff, strain, stress;
			logic [127:0] ms;
			e.f[0] = 0; e.f[1] = 0; e.f[2] = 0;
			e.strain = 0; e.stress = 0; e.stat = STAT_OK;
			if (r.mode == MODE_READ) begin
				for (int k = 0; k < 3; k++) begin
					e.f[k] = 32'(sum_f[k][r.idx1]);
					sum_f[k][r.idx1] = 0;
				end
			end else if (r.mode != MODE_NOP) begin
				clipped = 0;
				sq = 0;
				for (int k = 0; k < 3; k++) begin
					if (k == 2 && r.mode == MODE_2D) d[k] = 0;
					else d[k] = longint'(r.p2[k]) - longint'(r.p1[k]);
					md = (d[k] < 0) ? -d[k] : d[k];
					sq += md * md;
				end
				len = 0;
				for (int b = 34; b >= 0; b--) begin
					cand = len | (128'd1 << b);
					if (cand * cand <= sq) len = cand;
				end
				if (r.rest == 0) begin
					e.stat = STAT_ZERO_REST;
				end else begin
					diff   = longint'(len) - longint'(r.rest);
					strain = clip32((diff * 65536) / longint'(r.rest));
					stress = clip32((strain * longint'(r.stiff)) / 65536);
					e.strain = 32'(strain);
					e.stress = 32'(stress);
					if (len == 0) begin
						e.stat = STAT_ZERO_LEN;
					end else begin
						ms = (stress < 0) ? -stress : stress;
						for (int k = 0; k < 3; k++) begin
							md = (d[k] < 0) ? -d[k] : d[k];
							p  = md * ms / len;
							fv[k] = ((d[k] < 0) != (stress < 0)) ? -longint'(p)
								: longint'(p);
							fv[k] = clip32(fv[k]);
							e.f[k] = 32'(fv[k]);
						end
						// first particle gains the force, second loses it
						for (int k = 0; k < 3; k++)
							sum_f[k][r.idx1] = clip32(sum_f[k][r.idx1] + fv[k]);
						for (int k = 0; k < 3; k++)
							sum_f[k][r.idx2] = clip32(sum_f[k][r.idx2] - fv[k]);
					end
					if (clipped) e.stat = STAT_SAT;
				end
			end
			owed.push_back(e);
		endfunction

		function void check(spring_res_t a);
			spring_res_t e;
			if (owed.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			e = owed.pop_front();
			if (a.f[0] !== e.f[0]) begin
				$error("force_x: expected %0d, actual %0d", e.f[0], a.f[0]);
				errors++;
			end
			if (a.f[1] !== e.f[1]) begin
				$error("force_y: expected %0d, actual %0d", e.f[1], a.f[1]);
				errors++;
			end
			if (a.f[2] !== e.f[2]) begin
				$error("force_z: expected %0d, actual %0d", e.f[2], a.f[2]);
				errors++;
			end
			if (a.strain !== e.strain) begin
				$error("strain_value: expected %0d, actual %0d", e.strain, a.strain);
				errors++;
			end
			if (a.stress !== e.stress) begin
				$error("stress_value: expected %0d, actual %0d", e.stress, a.stress);
				errors++;
			end
			if (a.stat !== e.stat) begin
				$error("status: expected %0d, actual %0d", e.stat, a.stat);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [1:0]         mode;
	logic [7:0]         first_index;
	logic [7:0]         second_index;
	logic signed [31:0] first_x, first_y, first_z;
	logic signed [31:0] second_x, second_y, second_z;
	logic [30:0]        spring_stiffness;
	logic [30:0]        rest_length;
	logic               empty;
	logic               pop;
	logic signed [31:0] force_x, force_y, force_z;
	logic signed [31:0] strain_value, stress_value;
	logic [1:0]         status;

	force_scoreboard sb;
	int              cycles;
	int              pop_rate;

	linear_spring_force_unit #(.NUM_PARTICLES(PARTICLES)) dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.mode(mode), .first_index(first_index), .second_index(second_index),
		.first_x(first_x), .first_y(first_y), .first_z(first_z),
		.second_x(second_x), .second_y(second_y), .second_z(second_z),
		.spring_stiffness(spring_stiffness), .rest_length(rest_length),
		.empty(empty), .pop(pop),
		.force_x(force_x), .force_y(force_y), .force_z(force_z),
		.strain_value(strain_value), .stress_value(stress_value),
		.status(status)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// put a request on the ports and hold it until the unit takes it;
	// push stays high so a back-to-back request needs no second assignment
	task automatic send(spring_req_t r);
		push             <= 1'b1;
		mode             <= r.mode;
		first_index      <= r.idx1;
		second_index     <= r.idx2;
		first_x          <= r.p1[0];
		first_y          <= r.p1[1];
		first_z          <= r.p1[2];
		second_x         <= r.p2[0];
		second_y         <= r.p2[1];
		second_z         <= r.p2[2];
		spring_stiffness <= r.stiff;
		rest_length      <= r.rest;
		do @(posedge clk); while (full);
		sb.note(r);
	endtask

	// with n zero, push stays high for the next request
	task automatic idle(int n);
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic spring_req_t make_req(logic [1:0] m, int i1, int i2,
			longint a0, longint a1, longint a2, longint b0, longint b1, longint b2,
			longint k, longint rl);
		spring_req_t r;
		r.mode = m; r.idx1 = 8'(i1); r.idx2 = 8'(i2);
		r.p1[0] = 32'(a0); r.p1[1] = 32'(a1); r.p1[2] = 32'(a2);
		r.p2[0] = 32'(b0); r.p2[1] = 32'(b1); r.p2[2] = 32'(b2);
		r.stiff = 31'(k); r.rest = 31'(rl);
		return r;
	endfunction

	// random request: mostly well-formed springs on a few particles with
	// reads mixed in, some full-range noise and no-ops
	function automatic spring_req_t rand_req();
		spring_req_t r;
		int          sel, span;
		sel = $urandom_range(0, 99);
		for (int k = 0; k < 3; k++) begin
			r.p1[k] = $urandom;
			r.p2[k] = $urandom;
		end
		r.idx1  = 8'($urandom);
		r.idx2  = 8'($urandom);
		r.stiff = 31'($urandom);
		r.rest  = 31'($urandom);
		r.mode  = 2'($urandom);
		if (sel < 80) begin
			r.mode = $urandom_range(0, 1) ? MODE_3D : MODE_2D;
			r.idx1 = 8'($urandom_range(0, 7));
			r.idx2 = 8'($urandom_range(0, 7));
			span   = $urandom_range(0, 3) == 0 ? 30 : 22;
			for (int k = 0; k < 3; k++) begin
				r.p1[k] = $signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
				r.p2[k] = r.p1[k] + $signed($urandom_range(0, (1 << 20) - 1))
					- (1 << 19);
			end
			if ($urandom_range(0, 19) == 0) r.p2 = r.p1;
			r.stiff = 31'($urandom_range(0, 3) == 0 ? $urandom
				: $urandom_range(0, 1 << 20));
			r.rest  = 31'($urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 1 << 20));
		end else if (sel < 92) begin
			r.mode = MODE_READ;
			r.idx1 = 8'($urandom_range(0, 7));
		end else if (sel < 96) begin
			r.mode = MODE_NOP;
		end
		return r;
	endfunction

	// receiver: check each popped result, stall on a changing duty cycle
	always @(posedge clk) begin
		spring_res_t a;
		if (arst_n && pop && !empty) begin
			a.f[0] = force_x; a.f[1] = force_y; a.f[2] = force_z;
			a.strain = strain_value; a.stress = stress_value; a.stat = status;
			sb.check(a);
		end
		if (cycles % 300 == 0) pop_rate <= ($urandom_range(0, 2) == 0) ? 100
			: $urandom_range(5, 90);
		pop <= ($urandom_range(0, 99) < pop_rate);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** linear_spring_force_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		spring_req_t dir [$];
		int          burst;
		sb       = new();
		cycles   = 0;
		pop_rate = 100;
		arst_n   = 1'b0;
		push     = 1'b0;
		pop      = 1'b0;
		mode     = MODE_NOP;
		first_index = 0; second_index = 0;
		first_x = 0; first_y = 0; first_z = 0;
		second_x = 0; second_y = 0; second_z = 0;
		spring_stiffness = 0; rest_length = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed part
		dir.push_back(make_req(MODE_NOP, 255, 255, -1, -1, -1, -1, -1, -1,
			31'h7fffffff, 31'h7fffffff));
		dir.push_back(make_req(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// 3-4-5 triangle at rest, then stretched
		dir.push_back(make_req(MODE_2D, 1, 2, 0, 0, 0, 3 << 16, 4 << 16, 0,
			1 << 16, 5 << 16));
		dir.push_back(make_req(MODE_2D, 1, 2, 0, 0, 99, 6 << 16, 8 << 16, -7,
			2 << 16, 5 << 16));
		dir.push_back(make_req(MODE_3D, 1, 3, 1 << 16, 1 << 16, 1 << 16,
			-(2 << 16), 5 << 16, 13 << 16, 3 << 16, 10 << 16));
		// zero rest length
		dir.push_back(make_req(MODE_3D, 4, 5, 0, 0, 0, 1 << 16, 0, 0, 1 << 16, 0));
		// coincident points
		dir.push_back(make_req(MODE_2D, 4, 5, 7, 7, 7, 7, 7, 9, 1 << 16, 1 << 16));
		dir.push_back(make_req(MODE_3D, 4, 5, 7, 7, 7, 7, 7, 7, 31'h7fffffff, 1));
		// extreme spans, stiffness and rest
		dir.push_back(make_req(MODE_3D, 6, 7, -64'sd2147483648, -64'sd2147483648,
			-64'sd2147483648, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
			31'h7fffffff, 1));
		dir.push_back(make_req(MODE_2D, 6, 7, 64'sd2147483647, -64'sd2147483648, 0,
			-64'sd2147483648, 64'sd2147483647, 0, 31'h7fffffff, 31'h7fffffff));
		dir.push_back(make_req(MODE_3D, 6, 7, 0, 0, 0, 1, 0, 0, 31'h7fffffff,
			31'h7fffffff));
		// same particle on both ends
		dir.push_back(make_req(MODE_3D, 8, 8, 0, 0, 0, 1 << 18, 1 << 17, 1 << 16,
			1 << 16, 1 << 16));
		// the two top indices, one on each end
		dir.push_back(make_req(MODE_2D, 255, 254, 0, 0, 0, -(9 << 16), 12 << 16, 0,
			4 << 16, 1 << 16));
		// pile saturating forces on one pair of particles
		for (int n = 0; n < 4; n++)
			dir.push_back(make_req(MODE_2D, 9, 10, 0, 0, 0, 64'sd2147483647, 0, 0,
				31'h7fffffff, 1 << 10));
		dir.push_back(make_req(MODE_READ, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir.push_back(make_req(MODE_READ, 10, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir.push_back(make_req(MODE_READ, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir.push_back(make_req(MODE_READ, 254, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir.push_back(make_req(MODE_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir.push_back(make_req(MODE_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		foreach (dir[n]) send(dir[n]);

		// random part in bursts with gaps
		for (int n = 0; n < RANDOM_REQS; ) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && n < RANDOM_REQS; b++, n++) begin
				send(rand_req());
				// once midway: hold off until the unit has drained
				if (n == RANDOM_REQS / 2) begin
					push <= 1'b0;
					while (sb.owed.size() != 0) @(posedge clk);
				end
			end
			idle($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 200));
		end
		push <= 1'b0;

		while (sb.owed.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("** linear_spring_force_unit: PASSED **");
		else
			$display("** linear_spring_force_unit: FAILED **");
		$finish;
	end

endmodule

[filelist.f]
hdl/lsf_pkg.sv
hdl/lsf_ram.sv
hdl/lsf_mul.sv
hdl/lsf_div.sv
hdl/lsf_sqrt.sv
hdl/lsf_front.sv
hdl/lsf_back.sv
hdl/linear_spring_force_unit.sv
bench/tb_linear_spring_force_unit.sv
